// File: hw/rtl/ratiometric_battery_adc_sequencer_unit_macros.svh
// assertion macros shared by the battery sequencer rtl
// no dependencies; included by the files that carry assertions
`ifndef RATIOMETRIC_BATTERY_ADC_SEQUENCER_UNIT_MACROS_SVH
`define RATIOMETRIC_BATTERY_ADC_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define RBAS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rbas assertion failed");

// next-cycle implication, disabled while reset is active
`define RBAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rbas assertion failed");

`endif

// File: hw/rtl/rbas_pkg.sv
// types, constants and codes of the battery measurement sequencer
// no dependencies; imported by every module of the block
package rbas_pkg;

	localparam int TICK_BITS   = 16;
	localparam int SAMPLE_BITS = 10;
	localparam int GAIN_W      = 8;
	localparam int VDD_NUM_W   = 16;
	localparam int SETTLE_W    = 8;
	localparam int SCALED_W    = 8;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int NUM_W       = GAIN_W + SAMPLE_BITS;
	localparam int MUL_CNT_W   = $clog2(GAIN_W + 1);
	localparam int DIV_CNT_W   = $clog2(NUM_W + 1);

	localparam logic [VDD_NUM_W-1:0] VDD_NUM_RESET = 16'd62853;
	localparam logic [GAIN_W-1:0]    GAIN_RESET    = 8'd66;
	localparam logic [SETTLE_W-1:0]  SETTLE_RESET  = 8'd1;
	localparam logic [SCALED_W-1:0]  SCALED_MAX    = '1;

	localparam logic [1:0] CMD_POLL  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_VDD_NUM  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BAT_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 2'd2;

	typedef enum logic [2:0] {
		PH_STOPPED   = 3'd0,
		PH_SETUP_REF = 3'd1,
		PH_ACQ_REF   = 3'd2,
		PH_READ_REF  = 3'd3,
		PH_ACQ_BAT   = 3'd4,
		PH_READ_BAT  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		CTL_IDLE,
		CTL_STEP,
		CTL_DIV_VDD,
		CTL_BAT_GO,
		CTL_DIV_BAT,
		CTL_EMIT
	} ctl_t;

	typedef struct packed {
		logic [1:0]             cmd;
		logic [TICK_BITS-1:0]   tick_ms;
		logic                   conv_busy;
		logic [SAMPLE_BITS-1:0] conv_result;
	} in_item_t;

	typedef struct packed {
		logic                channel_select;
		logic                converter_enable;
		logic                conversion_go;
		logic                measurement_ready;
		logic [SCALED_W-1:0] vdd_scaled;
		logic [SCALED_W-1:0] bat_scaled;
	} out_item_t;

	// handshake between sequencer and the serial divider
	typedef struct packed {
		logic start;
		logic done;
		logic busy;
	} div_ctl_t;

endpackage

// File: hw/rtl/rbas_mul.sv
// bit-serial shift-add multiplier: battery gain times battery sample
// depends on rbas_pkg
module rbas_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rbas_pkg::GAIN_W-1:0]  gain,
	input  logic [rbas_pkg::SAMPLE_BITS-1:0] sample,
	output logic                         busy,
	output logic [rbas_pkg::NUM_W-1:0]   prod
);
	import rbas_pkg::*;

	logic                 busy_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [GAIN_W-1:0]    mplier_q;
	logic [NUM_W-1:0]     mcand_q;
	logic [NUM_W-1:0]     prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= MUL_CNT_W'(GAIN_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == MUL_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// one multiplier bit per cycle, lsb first
	always_ff @(posedge clk) begin
		if (start) begin
			prod_q   <= '0;
			mcand_q  <= NUM_W'(sample);
			mplier_q <= gain;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q  <= {mcand_q[NUM_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[GAIN_W-1:1]};
		end
	end

	assign busy = busy_q;
	assign prod = prod_q;

endmodule

// File: hw/rtl/rbas_div.sv
// bit-serial restoring divider with quotient saturated to 8 bits
// depends on rbas_pkg and the assertion macro header
`include "ratiometric_battery_adc_sequencer_unit_macros.svh"
module rbas_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [rbas_pkg::NUM_W-1:0]       num,
	input  logic [rbas_pkg::SAMPLE_BITS-1:0] den,
	output rbas_pkg::div_ctl_t               stat,
	output logic [rbas_pkg::SCALED_W-1:0]    quot
);
	import rbas_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [NUM_W-1:0]       num_q;
	logic [SAMPLE_BITS-1:0] den_q;
	logic [SAMPLE_BITS-1:0] rem_q;
	logic [SCALED_W-1:0]    quo_q;
	logic                   sat_q;

	logic [SAMPLE_BITS:0]   trial;
	logic [SAMPLE_BITS:0]   diff;
	logic                   ge;

	// a zero divisor sets every quotient bit, which saturates as required
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
			// any quotient bit above the low byte means saturation
			sat_q <= sat_q | quo_q[SCALED_W-1];
			quo_q <= {quo_q[SCALED_W-2:0], ge};
		end
	end

	assign stat.start = start;
	assign stat.done  = done_q;
	assign stat.busy  = busy_q;
	assign quot       = sat_q ? SCALED_MAX : quo_q;

	`RBAS_ASSERT_IMPLY(a_div_start_idle, clk, arst_n, start, !busy_q)
	`RBAS_ASSERT_NEXT(a_div_last_step, clk, arst_n, busy_q && cnt_q == DIV_CNT_W'(1), done_q && !busy_q)
	`RBAS_ASSERT_NEXT(a_div_done_pulse, clk, arst_n, done_q, !done_q)

endmodule

// File: hw/rtl/ratiometric_battery_adc_sequencer_unit.sv
// top level of the ratiometric battery measurement sequencer
// depends on rbas_pkg, rbas_mul, rbas_div and the assertion macro header
//
// usage: firmware-style poll items enter on the item channel (valid/stall); each
// accepted item gives exactly one result on the result channel (valid/stall)
// carrying converter controls and the latest scaled supply and battery values.
// cmd start clears the results and arms the cycle, stop powers the converter
// down, poll advances the reference / battery acquisition and conversion steps.
// flow: a normal item is stepped the cycle after its transfer, then placed in the
// output register from the emit state once that register is free or being drained.
// the item that finishes the battery conversion runs the serial divider twice (one
// quotient bit per cycle) before its result is handed over; the serial multiplier
// runs under the first division.
// one item is worked at a time: item_stall is high from transfer to hand-over
// into the output register, and hand-over waits while a stalled result still
// sits there. the next item may be taken once its predecessor is handed over.
// reset: phase stopped, held results and controls zero, registers at defaults.
// configuration writes are taken any cycle and meant for idle periods.
`include "ratiometric_battery_adc_sequencer_unit_macros.svh"
module ratiometric_battery_adc_sequencer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [rbas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbas_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  rbas_pkg::in_item_t              item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output rbas_pkg::out_item_t             result
);
	import rbas_pkg::*;

	// configuration registers
	logic [VDD_NUM_W-1:0] vdd_num_q;
	logic [GAIN_W-1:0]    gain_q;
	logic [SETTLE_W-1:0]  settle_q;

	// sequencer control
	ctl_t ctl_q, ctl_d;
	in_item_t item_q;
	logic accept;

	// measurement state
	phase_t                 phase_q, phase_d;
	logic [TICK_BITS-1:0]   start_tick_q, start_tick_d;
	logic [SAMPLE_BITS-1:0] ref_q, ref_d;
	logic [SCALED_W-1:0]    vdd_hold_q, vdd_hold_d;
	logic [SCALED_W-1:0]    bat_hold_q, bat_hold_d;
	logic                   en_hold_q, en_hold_d;
	logic                   ch_hold_q, ch_hold_d;
	logic                   go_q, go_d;
	logic                   ready_q, ready_d;

	// output register
	out_item_t out_q;
	logic      out_valid_q;
	logic      out_load;

	// arithmetic units
	logic                 mul_start;
	logic                 mul_busy;
	logic [NUM_W-1:0]     mul_prod;
	logic                 div_start;
	logic [NUM_W-1:0]     div_num;
	div_ctl_t             div_stat;
	logic [SCALED_W-1:0]  div_quot;

	logic [TICK_BITS-1:0] elapsed;
	logic                 settled;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (ctl_q != CTL_IDLE);

	// elapsed time wraps with the tick counter
	assign elapsed = item_q.tick_ms - start_tick_q;
	assign settled = elapsed > TICK_BITS'(settle_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vdd_num_q <= VDD_NUM_RESET;
			gain_q    <= GAIN_RESET;
			settle_q  <= SETTLE_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_VDD_NUM:  vdd_num_q <= cfg_data[VDD_NUM_W-1:0];
				CFG_BAT_GAIN: gain_q    <= cfg_data[GAIN_W-1:0];
				CFG_SETTLE:   settle_q  <= cfg_data[SETTLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q        <= CTL_IDLE;
			phase_q      <= PH_STOPPED;
			start_tick_q <= '0;
			ref_q        <= '0;
			vdd_hold_q   <= '0;
			bat_hold_q   <= '0;
			en_hold_q    <= 1'b0;
			ch_hold_q    <= 1'b0;
			go_q         <= 1'b0;
			ready_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			ctl_q        <= ctl_d;
			phase_q      <= phase_d;
			start_tick_q <= start_tick_d;
			ref_q        <= ref_d;
			vdd_hold_q   <= vdd_hold_d;
			bat_hold_q   <= bat_hold_d;
			en_hold_q    <= en_hold_d;
			ch_hold_q    <= ch_hold_d;
			go_q         <= go_d;
			ready_q      <= ready_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (out_load) begin
			out_q.channel_select    <= ch_hold_q;
			out_q.converter_enable  <= en_hold_q;
			out_q.conversion_go     <= go_q;
			out_q.measurement_ready <= ready_q;
			out_q.vdd_scaled        <= vdd_hold_q;
			out_q.bat_scaled        <= bat_hold_q;
		end
	end

	always_comb begin
		ctl_d        = ctl_q;
		phase_d      = phase_q;
		start_tick_d = start_tick_q;
		ref_d        = ref_q;
		vdd_hold_d   = vdd_hold_q;
		bat_hold_d   = bat_hold_q;
		en_hold_d    = en_hold_q;
		ch_hold_d    = ch_hold_q;
		go_d         = go_q;
		ready_d      = ready_q;
		mul_start    = 1'b0;
		div_start    = 1'b0;
		div_num      = mul_prod;
		out_load     = 1'b0;

		unique case (ctl_q)
			CTL_IDLE: begin
				if (accept) begin
					ctl_d = CTL_STEP;
				end
			end
			CTL_STEP: begin
				go_d    = 1'b0;
				ready_d = 1'b0;
				ctl_d   = CTL_EMIT;
				case (item_q.cmd)
					CMD_START: begin
						vdd_hold_d = '0;
						bat_hold_d = '0;
						phase_d    = PH_SETUP_REF;
					end
					CMD_STOP: begin
						en_hold_d = 1'b0;
						phase_d   = PH_STOPPED;
					end
					CMD_POLL: begin
						unique case (phase_q)
							PH_STOPPED: ;
							PH_SETUP_REF: begin
								ch_hold_d    = 1'b0;
								en_hold_d    = 1'b1;
								start_tick_d = item_q.tick_ms;
								phase_d      = PH_ACQ_REF;
							end
							PH_ACQ_REF: begin
								if (settled) begin
									go_d    = 1'b1;
									phase_d = PH_READ_REF;
								end
							end
							PH_READ_REF: begin
								if (!item_q.conv_busy) begin
									ref_d        = item_q.conv_result;
									ch_hold_d    = 1'b1;
									en_hold_d    = 1'b1;
									start_tick_d = item_q.tick_ms;
									phase_d      = PH_ACQ_BAT;
								end
							end
							PH_ACQ_BAT: begin
								if (settled) begin
									go_d    = 1'b1;
									phase_d = PH_READ_BAT;
								end
							end
							PH_READ_BAT: begin
								// both results follow; product runs under the first quotient
								if (!item_q.conv_busy) begin
									mul_start = 1'b1;
									div_start = 1'b1;
									div_num   = NUM_W'(vdd_num_q);
									ctl_d     = CTL_DIV_VDD;
								end
							end
							default: phase_d = PH_STOPPED;
						endcase
					end
					default: ;
				endcase
			end
			CTL_DIV_VDD: begin
				if (div_stat.done) begin
					vdd_hold_d = div_quot;
					ctl_d      = CTL_BAT_GO;
				end
			end
			CTL_BAT_GO: begin
				if (!mul_busy) begin
					div_start = 1'b1;
					ctl_d     = CTL_DIV_BAT;
				end
			end
			CTL_DIV_BAT: begin
				if (div_stat.done) begin
					bat_hold_d = div_quot;
					ready_d    = 1'b1;
					phase_d    = PH_SETUP_REF;
					ctl_d      = CTL_EMIT;
				end
			end
			CTL_EMIT: begin
				// hand over once the output register is free or being drained
				if (!out_valid_q || !result_stall) begin
					out_load = 1'b1;
					ctl_d    = CTL_IDLE;
				end
			end
			default: ctl_d = CTL_IDLE;
		endcase
	end

	rbas_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.gain   (gain_q),
		.sample (item_q.conv_result),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	rbas_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (ref_q),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`RBAS_ASSERT_IMPLY(a_done_expected, clk, arst_n, div_stat.done, ctl_q == CTL_DIV_VDD || ctl_q == CTL_DIV_BAT)
	`RBAS_ASSERT_NEXT(a_pair_done, clk, arst_n, ctl_q == CTL_DIV_BAT && div_stat.done, ready_q && phase_q == PH_SETUP_REF)
	`RBAS_ASSERT_IMPLY(a_go_ready_excl, clk, arst_n, 1'b1, !(go_q && ready_q))

endmodule

// File: bench/rbas_result_checker.sv
`timescale 1ns / 100ps
// result checker for the ratiometric battery sequencer: tracks phases and scaling
// per item transfer, compares each result transfer; depends on rbas_pkg only
module rbas_result_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [rbas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbas_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            item_valid,
	input  logic                            item_stall,
	input  rbas_pkg::in_item_t              item,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  rbas_pkg::out_item_t             result,
	output int                              mismatches,
	output int                              outstanding,
	output int                              results_seen,
	output int                              measurements
);
	import rbas_pkg::*;

	// sequencer state as the block should hold it
	phase_t                 seq_phase;
	logic [TICK_BITS-1:0]   acq_start;
	logic [SAMPLE_BITS-1:0] ref_sample;
	logic [SCALED_W-1:0]    vdd_latch;
	logic [SCALED_W-1:0]    bat_latch;
	logic                   power_latch;
	logic                   chan_latch;

	logic [VDD_NUM_W-1:0] vdd_num;
	logic [GAIN_W-1:0]    bat_gain;
	logic [SETTLE_W-1:0]  settle;

	out_item_t pending_results[$];
	out_item_t want;
	int        fail_total;
	int        seen_total;
	int        ready_total;

	function automatic logic [SCALED_W-1:0] clamp_ratio(input logic [NUM_W-1:0] num,
			input logic [SAMPLE_BITS-1:0] den);
		logic [NUM_W-1:0] q;
		if (den == '0)
			return SCALED_MAX;
		q = num / NUM_W'(den);
		return (q > NUM_W'(SCALED_MAX)) ? SCALED_MAX : q[SCALED_W-1:0];
	endfunction

	function automatic bit settled(input logic [TICK_BITS-1:0] now);
		logic [TICK_BITS-1:0] elapsed;
		elapsed = now - acq_start;
		return elapsed > TICK_BITS'(settle);
	endfunction

	function automatic out_item_t advance_sequencer(input in_item_t it);
		out_item_t r;
		logic      go;
		logic      ready;
		go = 1'b0;
		ready = 1'b0;
		case (it.cmd)
		CMD_START: begin
			vdd_latch = '0;
			bat_latch = '0;
			seq_phase = PH_SETUP_REF;
		end
		CMD_STOP: begin
			power_latch = 1'b0;
			seq_phase = PH_STOPPED;
		end
		CMD_POLL: begin
			case (seq_phase)
			PH_STOPPED: ;
			PH_SETUP_REF: begin
				chan_latch = 1'b0;
				power_latch = 1'b1;
				acq_start = it.tick_ms;
				seq_phase = PH_ACQ_REF;
			end
			PH_ACQ_REF: begin
				if (settled(it.tick_ms)) begin
					go = 1'b1;
					seq_phase = PH_READ_REF;
				end
			end
			PH_READ_REF: begin
				if (!it.conv_busy) begin
					ref_sample = it.conv_result;
					chan_latch = 1'b1;
					power_latch = 1'b1;
					acq_start = it.tick_ms;
					seq_phase = PH_ACQ_BAT;
				end
			end
			PH_ACQ_BAT: begin
				if (settled(it.tick_ms)) begin
					go = 1'b1;
					seq_phase = PH_READ_BAT;
				end
			end
			PH_READ_BAT: begin
				if (!it.conv_busy) begin
					vdd_latch = clamp_ratio(NUM_W'(vdd_num), ref_sample);
					bat_latch = clamp_ratio(NUM_W'(bat_gain) * NUM_W'(it.conv_result), ref_sample);
					ready = 1'b1;
					seq_phase = PH_SETUP_REF;
				end
			end
			default: seq_phase = PH_STOPPED;
			endcase
		end
		default: ;
		endcase
		r.channel_select = chan_latch;
		r.converter_enable = power_latch;
		r.conversion_go = go;
		r.measurement_ready = ready;
		r.vdd_scaled = vdd_latch;
		r.bat_scaled = bat_latch;
		return r;
	endfunction

	task automatic compare_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			fail_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_phase = PH_STOPPED;
			acq_start = '0;
			ref_sample = '0;
			vdd_latch = '0;
			bat_latch = '0;
			power_latch = 1'b0;
			chan_latch = 1'b0;
			vdd_num = VDD_NUM_RESET;
			bat_gain = GAIN_RESET;
			settle = SETTLE_RESET;
			pending_results.delete();
			fail_total = 0;
			seen_total = 0;
			ready_total = 0;
		end else begin
			// results leave before this edge's item could have produced one
			if (result_valid && !result_stall) begin
				seen_total++;
				if (pending_results.size() == 0) begin
					$error("result transfer with nothing predicted: %p", result);
					fail_total++;
				end else begin
					want = pending_results.pop_front();
					compare_field("channel_select", want.channel_select, result.channel_select);
					compare_field("converter_enable", want.converter_enable,
						result.converter_enable);
					compare_field("conversion_go", want.conversion_go, result.conversion_go);
					compare_field("measurement_ready", want.measurement_ready,
						result.measurement_ready);
					compare_field("vdd_scaled", want.vdd_scaled, result.vdd_scaled);
					compare_field("bat_scaled", want.bat_scaled, result.bat_scaled);
				end
			end
			if (cfg_write_en) begin
				case (cfg_index)
				CFG_VDD_NUM: vdd_num = cfg_data[VDD_NUM_W-1:0];
				CFG_BAT_GAIN: bat_gain = cfg_data[GAIN_W-1:0];
				CFG_SETTLE: settle = cfg_data[SETTLE_W-1:0];
				default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				want = advance_sequencer(item);
				if (want.measurement_ready)
					ready_total++;
				pending_results.push_back(want);
			end
		end
		mismatches <= fail_total;
		outstanding <= pending_results.size();
		results_seen <= seen_total;
		measurements <= ready_total;
	end

endmodule

// File: bench/ratiometric_battery_adc_sequencer_unit_test.sv
`timescale 1ns / 100ps
// top of the battery sequencer bench: clock, reset, register settings and poll streams
// depends on rbas_pkg, the sequencer rtl and rbas_result_checker
module ratiometric_battery_adc_sequencer_unit_test;
	import rbas_pkg::*;

	// the block ignores this command code
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// quiet cycles before the watchdog gives up, well above divider time plus both stalls
	localparam int QUIET_LIMIT = 2000;
	// settle time after the last result, above the two-division item latency
	localparam int DRAIN_CYCLES = 48;
	localparam int SETTING_COUNT = 7;
	localparam int ITEMS_PER_SETTING = 90;
	// final stretch of the run without any idling
	localparam int STEADY_ITEMS = 60;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	in_item_t              item_bus = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	out_item_t             result_bus;

	int mismatches;
	int outstanding;
	int results_seen;
	int measurements;

	// stimulus bookkeeping
	logic                 tx_idle = 1'b0;
	logic                 rx_idle = 1'b0;
	int                   stall_left = 0;
	logic [TICK_BITS-1:0] tick_now = '0;
	int                   cur_settle = 1;
	int                   items_sent = 0;
	int                   items_counted = 0;

	ratiometric_battery_adc_sequencer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_bus)
	);

	rbas_result_checker result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_bus),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.measurements (measurements)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver back-pressure: random stall bursts while enabled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (rx_idle && $urandom_range(0, 9) == 0) begin
			result_stall <= 1'b1;
			stall_left <= $urandom_range(0, 13);
		end else begin
			result_stall <= 1'b0;
		end
	end

	// watchdog: any transfer on either channel restarts the count
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
		$display("ratiometric_battery_adc_sequencer_unit regression: fail");
		$finish;
	end

	// one item transfer, with an optional sender gap first; valid stays up afterwards
	task automatic send_item(input logic [1:0] cmd, input logic [TICK_BITS-1:0] tick,
			input logic busy, input logic [SAMPLE_BITS-1:0] sample);
		in_item_t nxt;
		int       gap;
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			gap = $urandom_range(1, 14);
			repeat (gap) @(posedge clk);
		end
		nxt.cmd = cmd;
		nxt.tick_ms = tick;
		nxt.conv_busy = busy;
		nxt.conv_result = sample;
		item_bus <= nxt;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		items_sent++;
		if (cmd != CMD_UNUSED)
			items_counted++;
	endtask

	// drop valid and hold off until every predicted result has been taken
	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register writes back to back; upper data bits of narrow registers are junk on purpose
	task automatic apply_settings(input logic [VDD_NUM_W-1:0] vdd, input logic [GAIN_W-1:0] gain,
			input logic [SETTLE_W-1:0] settle);
		cfg_write_en <= 1'b1;
		cfg_index <= CFG_VDD_NUM;
		cfg_data <= vdd;
		@(posedge clk);
		cfg_index <= CFG_BAT_GAIN;
		cfg_data <= {8'($urandom_range(0, 255)), gain};
		@(posedge clk);
		cfg_index <= CFG_SETTLE;
		cfg_data <= {8'($urandom_range(0, 255)), settle};
		@(posedge clk);
		cfg_write_en <= 1'b0;
		cur_settle = settle;
	endtask

	// converter readings lean on zero, tiny references and full scale
	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return SAMPLE_BITS'($urandom_range(1, 7));
		2: return '1;
		default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// poll with the tick moved on, sized to the settle time, with an odd far jump
	task automatic poll_random();
		if ($urandom_range(0, 19) == 0)
			tick_now = TICK_BITS'($urandom);
		else
			tick_now = tick_now + TICK_BITS'($urandom_range(0, cur_settle / 8 + 2));
		send_item(CMD_POLL, tick_now, $urandom_range(0, 9) < 4, pick_sample());
	endtask

	// mostly a start followed by a poll run; sometimes pure command noise
	task automatic run_episode();
		int len;
		int k;
		int pick;
		len = $urandom_range(8, 80);
		if ($urandom_range(0, 9) == 0) begin
			for (k = 0; k < 10; k++)
				send_item(2'($urandom_range(0, 3)), TICK_BITS'($urandom), 1'($urandom),
					pick_sample());
		end else begin
			send_item(CMD_START, tick_now, 1'($urandom), pick_sample());
			for (k = 0; k < len; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 2)
					send_item(CMD_STOP, tick_now, 1'($urandom), pick_sample());
				else if (pick < 4)
					send_item(CMD_UNUSED, TICK_BITS'($urandom), 1'($urandom), pick_sample());
				else if (pick < 5)
					send_item(CMD_START, tick_now, 1'($urandom), pick_sample());
				else
					poll_random();
			end
		end
	endtask

	initial begin
		int seg;
		int goal;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle = 1'b1;
		rx_idle <= 1'b1;

		// directed walk at reset settings (settle 1, gain 66, numerator 62853)
		send_item(CMD_POLL, 16'd100, 1'b0, 10'd5);           // poll while stopped
		send_item(CMD_UNUSED, 16'hFFFF, 1'b1, 10'h3FF);      // unused code ignored
		send_item(CMD_STOP, 16'd0, 1'b0, 10'd0);             // stop while stopped
		send_item(CMD_START, 16'd0, 1'b0, 10'd0);
		send_item(CMD_POLL, 16'hFFFE, 1'b1, 10'd0);          // reference setup
		send_item(CMD_POLL, 16'hFFFF, 1'b0, 10'd0);          // one tick, not settled
		send_item(CMD_POLL, 16'h0000, 1'b0, 10'd0);          // settled across the wrap
		send_item(CMD_POLL, 16'd1, 1'b1, 10'd5);             // still converting
		send_item(CMD_POLL, 16'd0, 1'b0, 10'd0);             // zero reference reading
		send_item(CMD_POLL, 16'd2, 1'b0, 10'd0);             // battery conversion go
		send_item(CMD_POLL, 16'd2, 1'b0, 10'h3FF);           // both results forced to max
		send_item(CMD_POLL, 16'd10, 1'b0, 10'd0);            // next cycle setup
		send_item(CMD_POLL, 16'd12, 1'b0, 10'd0);
		send_item(CMD_POLL, 16'd12, 1'b0, 10'd200);          // small reference
		send_item(CMD_POLL, 16'd14, 1'b0, 10'd0);
		send_item(CMD_POLL, 16'd14, 1'b0, 10'h3FF);          // both quotients saturate
		send_item(CMD_POLL, 16'd20, 1'b0, 10'd0);
		send_item(CMD_START, 16'd21, 1'b0, 10'd0);           // restart mid-cycle clears
		send_item(CMD_POLL, 16'd30, 1'b0, 10'd0);
		send_item(CMD_POLL, 16'd40, 1'b0, 10'd0);
		send_item(CMD_STOP, 16'd41, 1'b1, 10'd0);            // stop while converting
		send_item(CMD_POLL, 16'd50, 1'b0, 10'd9);            // stopped, nothing moves
		send_item(CMD_START, 16'd51, 1'b0, 10'd0);
		send_item(CMD_POLL, 16'd52, 1'b0, 10'd0);
		tick_now = 16'd52;
		drain();

		// random runs over register settings: reset values, the extremes, then random ones
		for (seg = 0; seg < SETTING_COUNT; seg++) begin
			case (seg)
			0: ;
			1: apply_settings(16'd0, 8'd255, 8'd0);
			2: apply_settings(16'hFFFF, 8'd0, 8'd255);
			3: apply_settings(16'hFFFF, 8'd255, 8'd1);
			default: apply_settings(VDD_NUM_W'($urandom), GAIN_W'($urandom),
				SETTLE_W'($urandom_range(0, 40)));
			endcase
			goal = items_counted + ITEMS_PER_SETTING;
			while (items_counted < goal) begin
				if (seg == SETTING_COUNT - 1 && items_counted >= goal - STEADY_ITEMS) begin
					tx_idle = 1'b0;
					rx_idle <= 1'b0;
				end else begin
					tx_idle = $urandom_range(0, 3) != 0;
					rx_idle <= $urandom_range(0, 3) != 0;
				end
				run_episode();
			end
			drain();
		end

		$display("covered %0d item and %0d result transfers, %0d finished measurements,",
			items_sent, results_seen, measurements);
		$display("over %0d register settings incl. zero reference, wrap and saturation",
			SETTING_COUNT);
		if (outstanding != 0)
			$error("%0d predicted results never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0) begin
			$display("ratiometric_battery_adc_sequencer_unit regression: pass");
		end else begin
			$display("ratiometric_battery_adc_sequencer_unit regression: fail");
		end
		$finish;
	end

endmodule
